// File: rtl/core/csv_field_split_and_type_classify_assert.svh
// Assertion macros used by the CSV field splitter top level.
`ifndef CSV_FIELD_SPLIT_AND_TYPE_CLASSIFY_ASSERT_SVH
`define CSV_FIELD_SPLIT_AND_TYPE_CLASSIFY_ASSERT_SVH

// Same-cycle implication, checked on every rising edge of clk outside reset.
`define CFS_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, checked on every rising edge of clk outside reset.
`define CFS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// File: rtl/core/cfs_pkg.sv
// Shared types, character codes and pattern automata for the CSV field splitter.
package cfs_pkg;

	localparam int MAX_COLUMNS = 64;
	localparam int COL_IDX_W   = $clog2(MAX_COLUMNS);
	localparam int COL_CNT_W   = $clog2(MAX_COLUMNS + 1);

	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_QUOTE = 8'd34;
	localparam logic [7:0] CH_MINUS = 8'd45;
	localparam logic [7:0] CH_DOT   = 8'd46;
	localparam logic [7:0] CH_LOW_O = 8'd111;
	localparam logic [7:0] CH_LOW_T = 8'd116;
	localparam logic [7:0] CH_SEMI  = 8'd59;
	localparam logic [7:0] LEN_MAX  = 8'd255;
	localparam logic [7:0] LONG_LIMIT_RESET = 8'd40;

	// Register indexes on the configuration port.
	localparam logic REG_SEPARATOR  = 1'b0;
	localparam logic REG_LONG_LIMIT = 1'b1;

	typedef enum logic [2:0] {
		FT_ID     = 3'd0,
		FT_DATE   = 3'd1,
		FT_RANGE  = 3'd2,
		FT_DOUBLE = 3'd3,
		FT_INT    = 3'd4,
		FT_STRING = 3'd5,
		FT_LONG   = 3'd6
	} field_type_t;

	typedef enum logic [3:0] {
		ID_S0 = 4'd0, ID_S1 = 4'd1, ID_S2 = 4'd2, ID_S3 = 4'd3, ID_S4 = 4'd4,
		ID_S5 = 4'd5, ID_S6 = 4'd6, ID_S7 = 4'd7, ID_S8 = 4'd8, ID_S9 = 4'd9,
		ID_DEAD = 4'd15
	} id_st_t;

	typedef enum logic [3:0] {
		DT_S0 = 4'd0, DT_S1 = 4'd1, DT_S2 = 4'd2, DT_S3 = 4'd3, DT_S4 = 4'd4,
		DT_S5 = 4'd5, DT_S6 = 4'd6, DT_S7 = 4'd7, DT_S8 = 4'd8, DT_S9 = 4'd9,
		DT_DEAD = 4'd15
	} date_st_t;

	typedef enum logic [3:0] {
		DD_S0 = 4'd0, DD_S1 = 4'd1, DD_S2 = 4'd2, DD_S3 = 4'd3, DD_S4 = 4'd4,
		DD_S5 = 4'd5, DD_S6 = 4'd6, DD_S7 = 4'd7, DD_S8 = 4'd8, DD_S9 = 4'd9,
		DD_S10 = 4'd10, DD_DEAD = 4'd15
	} dot_st_t;

	typedef enum logic [3:0] {
		RG_S0 = 4'd0, RG_S1 = 4'd1, RG_S2 = 4'd2, RG_S3 = 4'd3, RG_S4 = 4'd4,
		RG_S5 = 4'd5, RG_S6 = 4'd6, RG_DEAD = 4'd15
	} rng_st_t;

	typedef enum logic [2:0] {
		DC_S0 = 3'd0, DC_S1 = 3'd1, DC_S2 = 3'd2, DC_S3 = 3'd3, DC_S4 = 3'd4,
		DC_DEAD = 3'd7
	} dec_st_t;

	typedef enum logic [1:0] {
		IN_S0 = 2'd0, IN_S1 = 2'd1, IN_S2 = 2'd2, IN_DEAD = 2'd3
	} int_st_t;

	typedef struct packed {
		id_st_t   id;
		date_st_t date;
		dot_st_t  dotted;
		rng_st_t  rng;
		dec_st_t  dec;
		int_st_t  intg;
	} dfa_t;

	localparam dfa_t DFA_START = '{ID_S0, DT_S0, DD_S0, RG_S0, DC_S0, IN_S0};
	localparam dfa_t DFA_DEAD  = '{ID_DEAD, DT_DEAD, DD_DEAD, RG_DEAD, DC_DEAD, IN_DEAD};

	typedef struct packed {
		logic [COL_IDX_W-1:0] column_index;
		logic                 column_overflow;
		field_type_t          field_type;
		logic [7:0]           field_length;
		logic                 last_in_line;
	} result_t;

	function automatic logic is_dig(input logic [7:0] c);
		return (c >= 8'd48) && (c <= 8'd57);
	endfunction

	function automatic logic is_alp(input logic [7:0] c);
		return ((c >= 8'd65) && (c <= 8'd90)) || ((c >= 8'd97) && (c <= 8'd122));
	endfunction

	function automatic id_st_t next_id(input id_st_t s, input logic [7:0] c);
		logic d;
		logic a;
		d = is_dig(c);
		a = is_alp(c);
		case (s)
			ID_S0: return d ? ID_S1 : ID_DEAD;
			ID_S1: return d ? ID_S2 : a ? ID_S4 : ID_DEAD;
			ID_S2: return d ? ID_S3 : a ? ID_S4 : ID_DEAD;
			ID_S3: return a ? ID_S4 : ID_DEAD;
			ID_S4: return a ? ID_S5 : ID_DEAD;
			ID_S5: return a ? ID_S6 : d ? ID_S7 : ID_DEAD;
			ID_S6: return d ? ID_S7 : ID_DEAD;
			ID_S7: return d ? ID_S8 : ID_DEAD;
			ID_S8: return d ? ID_S9 : ID_DEAD;
			default: return ID_DEAD;
		endcase
	endfunction

	function automatic date_st_t next_date(input date_st_t s, input logic [7:0] c);
		logic d;
		logic a;
		logic m;
		d = is_dig(c);
		a = is_alp(c);
		m = (c == CH_MINUS);
		case (s)
			DT_S0: return d ? DT_S1 : a ? DT_S4 : DT_DEAD;
			DT_S1: return d ? DT_S2 : m ? DT_S3 : DT_DEAD;
			DT_S2: return m ? DT_S3 : DT_DEAD;
			DT_S3: return a ? DT_S4 : DT_DEAD;
			DT_S4: return a ? DT_S5 : DT_DEAD;
			DT_S5: return a ? DT_S6 : m ? DT_S7 : DT_DEAD;
			DT_S6: return m ? DT_S7 : DT_DEAD;
			DT_S7: return d ? DT_S8 : DT_DEAD;
			DT_S8: return d ? DT_S9 : DT_DEAD;
			default: return DT_DEAD;
		endcase
	endfunction

	function automatic dot_st_t next_dotted(input dot_st_t s, input logic [7:0] c);
		logic d;
		logic a;
		logic sp;
		logic dt;
		d  = is_dig(c);
		a  = is_alp(c);
		sp = (c == CH_SPACE);
		dt = (c == CH_DOT);
		case (s)
			DD_S0: return d ? DD_S1 : DD_DEAD;
			DD_S1: return d ? DD_S2 : dt ? DD_S3 : DD_DEAD;
			DD_S2: return dt ? DD_S3 : DD_DEAD;
			DD_S3: return sp ? DD_S4 : DD_DEAD;
			DD_S4: return a ? DD_S5 : DD_DEAD;
			DD_S5: return a ? DD_S6 : DD_DEAD;
			DD_S6: return a ? DD_S7 : sp ? DD_S8 : DD_DEAD;
			DD_S7: return sp ? DD_S8 : DD_DEAD;
			DD_S8: return d ? DD_S9 : DD_DEAD;
			DD_S9: return d ? DD_S10 : DD_DEAD;
			default: return DD_DEAD;
		endcase
	endfunction

	function automatic rng_st_t next_rng(input rng_st_t s, input logic [7:0] c);
		logic n;
		logic sp;
		logic m;
		logic t;
		n  = is_dig(c) || (c == CH_DOT);
		sp = (c == CH_SPACE);
		m  = (c == CH_MINUS);
		t  = (c == CH_LOW_T);
		case (s)
			RG_S0: return n ? RG_S1 : RG_DEAD;
			RG_S1: return n ? RG_S1 : sp ? RG_S2 : m ? RG_S4 : t ? RG_S3 : RG_DEAD;
			RG_S2: return m ? RG_S4 : t ? RG_S3 : RG_DEAD;
			RG_S3: return (c == CH_LOW_O) ? RG_S4 : RG_DEAD;
			RG_S4: return sp ? RG_S5 : n ? RG_S6 : RG_DEAD;
			RG_S5: return n ? RG_S6 : RG_DEAD;
			RG_S6: return n ? RG_S6 : RG_DEAD;
			default: return RG_DEAD;
		endcase
	endfunction

	function automatic dec_st_t next_dec(input dec_st_t s, input logic [7:0] c);
		logic d;
		d = is_dig(c);
		case (s)
			DC_S0: return (c == CH_MINUS) ? DC_S1 : d ? DC_S2 : DC_DEAD;
			DC_S1: return d ? DC_S2 : DC_DEAD;
			DC_S2: return d ? DC_S2 : (c == CH_DOT) ? DC_S3 : DC_DEAD;
			DC_S3: return d ? DC_S4 : DC_DEAD;
			DC_S4: return d ? DC_S4 : DC_DEAD;
			default: return DC_DEAD;
		endcase
	endfunction

	function automatic int_st_t next_int(input int_st_t s, input logic [7:0] c);
		logic d;
		d = is_dig(c);
		case (s)
			IN_S0: return (c == CH_MINUS) ? IN_S1 : d ? IN_S2 : IN_DEAD;
			IN_S1: return d ? IN_S2 : IN_DEAD;
			IN_S2: return d ? IN_S2 : IN_DEAD;
			default: return IN_DEAD;
		endcase
	endfunction

	// Advances all six pattern automata by one byte.
	function automatic dfa_t feed(input dfa_t s, input logic [7:0] c);
		dfa_t n;
		n.id     = next_id(s.id, c);
		n.date   = next_date(s.date, c);
		n.dotted = next_dotted(s.dotted, c);
		n.rng    = next_rng(s.rng, c);
		n.dec    = next_dec(s.dec, c);
		n.intg   = next_int(s.intg, c);
		return n;
	endfunction

endpackage

// File: rtl/core/cfs_field_unit.sv
// Field state, pattern automata and result formation for one byte beat.
module cfs_field_unit
	import cfs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       advance,
	input  logic [7:0] char_byte,
	input  logic       line_end,
	input  logic [7:0] separator_char,
	input  logic [7:0] long_string_limit,
	output logic       emit,
	output result_t    result
);

	logic                 in_quotes_q;
	logic                 raw_nonempty_q;
	logic                 content_started_q;
	logic [7:0]           pending_spaces_q;
	logic [7:0]           trimmed_length_q;
	logic [COL_CNT_W-1:0] column_q;
	dfa_t                 dfa_q;

	logic                 in_quotes_d;
	logic                 raw_nonempty_d;
	logic                 content_started_d;
	logic [7:0]           pending_spaces_d;
	logic [7:0]           trimmed_length_d;
	logic [COL_CNT_W-1:0] column_d;
	dfa_t                 dfa_d;

	logic                 append_en;
	logic                 clear_field;
	logic                 col_ovf;
	logic                 col_sat_inc;
	dfa_t                 dfa_sp1;
	dfa_t                 dfa_sp2;
	dfa_t                 dfa_pre;
	dfa_t                 dfa_app;
	logic [8:0]           len_sum;
	logic [7:0]           len_pre;
	logic [7:0]           len_app;
	field_type_t          ftype;

	// Held-back inner spaces are fed ahead of the next content byte.
	always_comb begin
		dfa_sp1 = feed(dfa_q, CH_SPACE);
		dfa_sp2 = feed(dfa_sp1, CH_SPACE);
		case (pending_spaces_q)
			8'd0: dfa_pre = dfa_q;
			8'd1: dfa_pre = dfa_sp1;
			8'd2: dfa_pre = dfa_sp2;
			default: dfa_pre = DFA_DEAD;
		endcase
		dfa_app = feed(dfa_pre, char_byte);
		len_sum = {1'b0, trimmed_length_q} + {1'b0, pending_spaces_q};
		len_pre = len_sum[8] ? LEN_MAX : len_sum[7:0];
		len_app = (len_pre != LEN_MAX) ? len_pre + 8'd1 : len_pre;
	end

	always_comb begin
		if ((dfa_q.id == ID_S8) || (dfa_q.id == ID_S9)) begin
			ftype = FT_ID;
		end else if ((dfa_q.date == DT_S9) || (dfa_q.dotted == DD_S10)) begin
			ftype = FT_DATE;
		end else if (dfa_q.rng == RG_S6) begin
			ftype = FT_RANGE;
		end else if (dfa_q.dec == DC_S4) begin
			ftype = FT_DOUBLE;
		end else if (dfa_q.intg == IN_S2) begin
			ftype = FT_INT;
		end else if (trimmed_length_q > long_string_limit) begin
			ftype = FT_LONG;
		end else begin
			ftype = FT_STRING;
		end
	end

	assign col_ovf     = (column_q == COL_CNT_W'(MAX_COLUMNS));
	assign col_sat_inc = !col_ovf;

	assign result.column_index    = col_ovf ? COL_IDX_W'(MAX_COLUMNS - 1)
	                                        : column_q[COL_IDX_W-1:0];
	assign result.column_overflow = col_ovf;
	assign result.field_type      = ftype;
	assign result.field_length    = trimmed_length_q;
	assign result.last_in_line    = line_end;

	always_comb begin
		emit        = 1'b0;
		append_en   = 1'b0;
		clear_field = 1'b0;
		in_quotes_d = in_quotes_q;
		column_d    = column_q;
		if (line_end) begin
			emit        = raw_nonempty_q;
			clear_field = 1'b1;
			in_quotes_d = 1'b0;
			column_d    = '0;
		end else if ((char_byte == CH_CR) || (char_byte == CH_LF)) begin
			emit = 1'b0;
		end else if (in_quotes_q) begin
			if (char_byte == CH_QUOTE) begin
				in_quotes_d = 1'b0;
			end else begin
				append_en = 1'b1;
			end
		end else if (char_byte == separator_char) begin
			emit        = 1'b1;
			clear_field = 1'b1;
			if (col_sat_inc) begin
				column_d = column_q + COL_CNT_W'(1);
			end
		end else if (char_byte == CH_QUOTE) begin
			in_quotes_d = 1'b1;
		end else begin
			append_en = 1'b1;
		end

		raw_nonempty_d    = raw_nonempty_q;
		content_started_d = content_started_q;
		pending_spaces_d  = pending_spaces_q;
		trimmed_length_d  = trimmed_length_q;
		dfa_d             = dfa_q;
		if (clear_field) begin
			raw_nonempty_d    = 1'b0;
			content_started_d = 1'b0;
			pending_spaces_d  = '0;
			trimmed_length_d  = '0;
			dfa_d             = DFA_START;
		end else if (append_en) begin
			raw_nonempty_d = 1'b1;
			if (char_byte == CH_SPACE) begin
				if (content_started_q && (pending_spaces_q != LEN_MAX)) begin
					pending_spaces_d = pending_spaces_q + 8'd1;
				end
			end else begin
				pending_spaces_d  = '0;
				trimmed_length_d  = len_app;
				dfa_d             = dfa_app;
				content_started_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_quotes_q       <= 1'b0;
			raw_nonempty_q    <= 1'b0;
			content_started_q <= 1'b0;
			pending_spaces_q  <= '0;
			trimmed_length_q  <= '0;
			column_q          <= '0;
			dfa_q             <= DFA_START;
		end else if (advance) begin
			in_quotes_q       <= in_quotes_d;
			raw_nonempty_q    <= raw_nonempty_d;
			content_started_q <= content_started_d;
			pending_spaces_q  <= pending_spaces_d;
			trimmed_length_q  <= trimmed_length_d;
			column_q          <= column_d;
			dfa_q             <= dfa_d;
		end
	end

endmodule

// File: rtl/core/csv_field_split_and_type_classify.sv
// Top level of the CSV field splitter with streaming field type classification.
// One line byte, or one end-of-line marker, enters per beat on the input channel
// and the block sustains one beat per clock: a beat is captured in an input
// register, the field state and six small pattern automata advance in a single
// combinational pass behind it, and any finished field lands in an output
// register. A separator byte outside quotes, other than CR or LF, always produces
// a result beat (an empty field reports as a string of length zero); the
// end-of-line marker produces one only if the open field received any byte other
// than a quote, CR or LF, and then carries last_in_line. CR and LF are dropped, a
// double quote toggles literal mode and is itself dropped, and leading and
// trailing spaces are trimmed. Types are checked in the order id, date, range,
// double, integer; otherwise the field is a long string when its trimmed length
// exceeds long_string_limit, else a string. Columns count up to 63 and further
// fields report column 63 with column_overflow set. The input keeps flowing while
// a result beat waits on a stalled output: only a beat that itself produces a
// result waits for the output register to free up.
// Registers (byte addresses): 0x0 separator_char (reset ';'), 0x4
// long_string_limit (reset 40). Write them only while the block is idle.
`include "csv_field_split_and_type_classify_assert.svh"

module csv_field_split_and_type_classify
	import cfs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// APB configuration port
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	// Byte input channel
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           char_byte,
	input  logic                 line_end,
	// Field result channel
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [COL_IDX_W-1:0] column_index,
	output logic                 column_overflow,
	output logic [2:0]           field_type,
	output logic [7:0]           field_length,
	output logic                 last_in_line
);

	logic [7:0] separator_q;
	logic [7:0] long_limit_q;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       line_end_s1;

	logic       out_valid_q;
	result_t    out_q;

	logic       emit;
	result_t    result;
	logic       out_free;
	logic       adv_s1;
	logic       in_accept;
	logic       cfg_write;

	// Configuration registers.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			separator_q  <= CH_SEMI;
			long_limit_q <= LONG_LIMIT_RESET;
		end else if (cfg_write) begin
			case (paddr[2])
				REG_SEPARATOR: separator_q <= pwdata[7:0];
				REG_LONG_LIMIT: long_limit_q <= pwdata[7:0];
				default: separator_q <= separator_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_SEPARATOR: prdata = {24'd0, separator_q};
			REG_LONG_LIMIT: prdata = {24'd0, long_limit_q};
			default: prdata = '0;
		endcase
	end

	// The beat in the input register moves on unless it finishes a field while
	// the output register is still holding an untaken result.
	assign out_free  = !out_valid_q || !out_stall;
	assign adv_s1    = valid_s1 && (!emit || out_free);
	assign in_stall  = valid_s1 && !adv_s1;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			byte_s1     <= char_byte;
			line_end_s1 <= line_end;
		end
	end

	cfs_field_unit u_field (
		.clk               (clk),
		.arst_n            (arst_n),
		.advance           (adv_s1),
		.char_byte         (byte_s1),
		.line_end          (line_end_s1),
		.separator_char    (separator_q),
		.long_string_limit (long_limit_q),
		.emit              (emit),
		.result            (result)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && emit) begin
			out_q <= result;
		end
	end

	assign out_valid       = out_valid_q;
	assign column_index    = out_q.column_index;
	assign column_overflow = out_q.column_overflow;
	assign field_type      = out_q.field_type;
	assign field_length    = out_q.field_length;
	assign last_in_line    = out_q.last_in_line;

	`CFS_ASSERT_IMP(a_stall_needs_beat, in_stall, valid_s1 && emit && out_valid_q)
	`CFS_ASSERT_NEXT(a_emit_loads_out, adv_s1 && emit, out_valid_q)
	`CFS_ASSERT_IMP(a_ovf_last_col, out_valid_q && out_q.column_overflow,
		out_q.column_index == COL_IDX_W'(MAX_COLUMNS - 1))
	`CFS_ASSERT_IMP(a_long_over_limit, out_valid_q && (out_q.field_type == FT_LONG),
		out_q.field_length > long_limit_q)

endmodule

// File: tb/sv/tb.sv
// Testbench for the CSV field splitter: random lines, a running field predictor, beat checks.
`timescale 1ns / 1ps

// The bench streams lines of text into the splitter and checks every field beat that comes out.
// An initial block builds lines of well-formed and broken fields into a queue of pending beats.
// It also writes the two registers between phases while the splitter is idle. A clocked driver
// sends the queue at the falling edge. A clocked monitor samples both channels at the rising
// edge. For every accepted input beat the monitor advances a private copy of the field state
// and the six pattern automata. That copy queues the field that the beat should close, if any.
// Every accepted output beat is compared field by field with the oldest queued field.
module tb
	import cfs_pkg::*;
();

	localparam logic [7:0] CH_COMMA = 8'd44;

	// Kinds of generated field content.
	localparam int K_ID     = 0;
	localparam int K_DATE   = 1;
	localparam int K_DOTTED = 2;
	localparam int K_RANGE  = 3;
	localparam int K_DOUBLE = 4;
	localparam int K_INT    = 5;
	localparam int K_TEXT   = 6;
	localparam int K_LONG   = 7;
	localparam int K_HUGE   = 8;
	localparam int K_NOISE  = 9;
	localparam int K_EMPTY  = 10;

	typedef struct packed {
		logic [7:0] ch;
		logic       eol;
	} beat_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [2:0]           paddr = '0;
	logic [31:0]          pwdata = '0;
	logic [31:0]          prdata;
	logic                 pready;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [7:0]           char_byte = '0;
	logic                 line_end = 1'b0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [COL_IDX_W-1:0] column_index;
	logic                 column_overflow;
	logic [2:0]           field_type;
	logic [7:0]           field_length;
	logic                 last_in_line;

	csv_field_split_and_type_classify u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.char_byte       (char_byte),
		.line_end        (line_end),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.column_index    (column_index),
		.column_overflow (column_overflow),
		.field_type      (field_type),
		.field_length    (field_length),
		.last_in_line    (last_in_line)
	);

	always #5 clk = ~clk;

	// Beats waiting to be sent, and fields the splitter still owes us.
	beat_t   beats_pending[$];
	result_t fields_due[$];
	int      stim_count = 0;
	int      mismatches = 0;

	// Acceptance seen at the last rising edge, used by the falling-edge drivers.
	logic in_fire = 1'b0;
	logic out_fire = 1'b0;

	// Private copy of the register file and of the field state.
	logic [7:0] sep_char = CH_SEMI;
	logic [7:0] long_limit = LONG_LIMIT_RESET;
	logic       quoted_mode = 1'b0;
	logic       field_touched = 1'b0;
	logic       text_started = 1'b0;
	int         held_spaces = 0;
	int         field_len = 0;
	int         col_count = 0;
	dfa_t       pat = DFA_START;

	// Set per generated field; a broken field draws its counts from 0 to one above the upper limit.
	bit broken = 1'b0;

	// ---------------------------------------------------------------------------------------
	// Pattern automata. Each one walks its own state on one byte; any miss is a dead state
	// that never recovers.
	// ---------------------------------------------------------------------------------------
	function automatic logic digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic letter(input logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	// Digits 1..3, letters 2..3, digits 2..3.
	function automatic id_st_t walk_id(input id_st_t s, input logic [7:0] c);
		logic d;
		logic a;
		d = digit(c);
		a = letter(c);
		case (s)
			ID_S0: return d ? ID_S1 : ID_DEAD;
			ID_S1: return d ? ID_S2 : (a ? ID_S4 : ID_DEAD);
			ID_S2: return d ? ID_S3 : (a ? ID_S4 : ID_DEAD);
			ID_S3: return a ? ID_S4 : ID_DEAD;
			ID_S4: return a ? ID_S5 : ID_DEAD;
			ID_S5: return a ? ID_S6 : (d ? ID_S7 : ID_DEAD);
			ID_S6: return d ? ID_S7 : ID_DEAD;
			ID_S7: return d ? ID_S8 : ID_DEAD;
			ID_S8: return d ? ID_S9 : ID_DEAD;
			default: return ID_DEAD;
		endcase
	endfunction

	// Optional day and dash, month of 2..3 letters, dash, two-digit year.
	function automatic date_st_t walk_date(input date_st_t s, input logic [7:0] c);
		logic d;
		logic a;
		logic m;
		d = digit(c);
		a = letter(c);
		m = (c == CH_MINUS);
		case (s)
			DT_S0: return d ? DT_S1 : (a ? DT_S4 : DT_DEAD);
			DT_S1: return d ? DT_S2 : (m ? DT_S3 : DT_DEAD);
			DT_S2: return m ? DT_S3 : DT_DEAD;
			DT_S3: return a ? DT_S4 : DT_DEAD;
			DT_S4: return a ? DT_S5 : DT_DEAD;
			DT_S5: return a ? DT_S6 : (m ? DT_S7 : DT_DEAD);
			DT_S6: return m ? DT_S7 : DT_DEAD;
			DT_S7: return d ? DT_S8 : DT_DEAD;
			DT_S8: return d ? DT_S9 : DT_DEAD;
			default: return DT_DEAD;
		endcase
	endfunction

	// Day, dot, space, month of 2..3 letters, space, two-digit year.
	function automatic dot_st_t walk_dotted(input dot_st_t s, input logic [7:0] c);
		logic d;
		logic a;
		logic sp;
		d = digit(c);
		a = letter(c);
		sp = (c == CH_SPACE);
		case (s)
			DD_S0: return d ? DD_S1 : DD_DEAD;
			DD_S1: return d ? DD_S2 : ((c == CH_DOT) ? DD_S3 : DD_DEAD);
			DD_S2: return (c == CH_DOT) ? DD_S3 : DD_DEAD;
			DD_S3: return sp ? DD_S4 : DD_DEAD;
			DD_S4: return a ? DD_S5 : DD_DEAD;
			DD_S5: return a ? DD_S6 : DD_DEAD;
			DD_S6: return a ? DD_S7 : (sp ? DD_S8 : DD_DEAD);
			DD_S7: return sp ? DD_S8 : DD_DEAD;
			DD_S8: return d ? DD_S9 : DD_DEAD;
			DD_S9: return d ? DD_S10 : DD_DEAD;
			default: return DD_DEAD;
		endcase
	endfunction

	// Number, optional space, dash or "to", optional space, number.
	function automatic rng_st_t walk_range(input rng_st_t s, input logic [7:0] c);
		logic n;
		logic sp;
		logic m;
		n = digit(c) || (c == CH_DOT);
		sp = (c == CH_SPACE);
		m = (c == CH_MINUS);
		case (s)
			RG_S0: return n ? RG_S1 : RG_DEAD;
			RG_S1: begin
				if (n) return RG_S1;
				if (sp) return RG_S2;
				if (m) return RG_S4;
				return (c == CH_LOW_T) ? RG_S3 : RG_DEAD;
			end
			RG_S2: return m ? RG_S4 : ((c == CH_LOW_T) ? RG_S3 : RG_DEAD);
			RG_S3: return (c == CH_LOW_O) ? RG_S4 : RG_DEAD;
			RG_S4: return sp ? RG_S5 : (n ? RG_S6 : RG_DEAD);
			RG_S5: return n ? RG_S6 : RG_DEAD;
			RG_S6: return n ? RG_S6 : RG_DEAD;
			default: return RG_DEAD;
		endcase
	endfunction

	function automatic dec_st_t walk_double(input dec_st_t s, input logic [7:0] c);
		logic d;
		d = digit(c);
		case (s)
			DC_S0: return (c == CH_MINUS) ? DC_S1 : (d ? DC_S2 : DC_DEAD);
			DC_S1: return d ? DC_S2 : DC_DEAD;
			DC_S2: return d ? DC_S2 : ((c == CH_DOT) ? DC_S3 : DC_DEAD);
			DC_S3: return d ? DC_S4 : DC_DEAD;
			DC_S4: return d ? DC_S4 : DC_DEAD;
			default: return DC_DEAD;
		endcase
	endfunction

	function automatic int_st_t walk_int(input int_st_t s, input logic [7:0] c);
		logic d;
		d = digit(c);
		case (s)
			IN_S0: return (c == CH_MINUS) ? IN_S1 : (d ? IN_S2 : IN_DEAD);
			IN_S1: return d ? IN_S2 : IN_DEAD;
			IN_S2: return d ? IN_S2 : IN_DEAD;
			default: return IN_DEAD;
		endcase
	endfunction

	function automatic dfa_t walk_all(input dfa_t s, input logic [7:0] c);
		dfa_t n;
		n.id     = walk_id(s.id, c);
		n.date   = walk_date(s.date, c);
		n.dotted = walk_dotted(s.dotted, c);
		n.rng    = walk_range(s.rng, c);
		n.dec    = walk_double(s.dec, c);
		n.intg   = walk_int(s.intg, c);
		return n;
	endfunction

	// ---------------------------------------------------------------------------------------
	// Field predictor.
	// ---------------------------------------------------------------------------------------
	task automatic reset_field();
		field_touched = 1'b0;
		text_started = 1'b0;
		held_spaces = 0;
		field_len = 0;
		pat = DFA_START;
	endtask

	// Adds one text byte to the open field. Spaces after content are held back and only count
	// once more text follows, so trailing spaces vanish. A run of more than two held spaces
	// kills every pattern at once.
	task automatic add_to_field(input logic [7:0] c);
		field_touched = 1'b1;
		if (c == CH_SPACE) begin
			if (text_started && held_spaces < 255)
				held_spaces++;
			return;
		end
		if (held_spaces > 0) begin
			if (held_spaces > 2)
				pat = DFA_DEAD;
			else
				repeat (held_spaces) pat = walk_all(pat, CH_SPACE);
			field_len += held_spaces;
			if (field_len > 255)
				field_len = 255;
			held_spaces = 0;
		end
		pat = walk_all(pat, c);
		if (field_len < 255)
			field_len++;
		text_started = 1'b1;
	endtask

	// The first pattern that matched wins; otherwise the trimmed length picks the string kind.
	function automatic field_type_t classify_field();
		if (pat.id == ID_S8 || pat.id == ID_S9) return FT_ID;
		if (pat.date == DT_S9 || pat.dotted == DD_S10) return FT_DATE;
		if (pat.rng == RG_S6) return FT_RANGE;
		if (pat.dec == DC_S4) return FT_DOUBLE;
		if (pat.intg == IN_S2) return FT_INT;
		return (field_len > long_limit) ? FT_LONG : FT_STRING;
	endfunction

	// Queues the field that is being closed. Columns past the last one report the last column
	// with the overflow flag.
	task automatic close_field(input logic last);
		result_t r;
		r.column_overflow = (col_count >= MAX_COLUMNS);
		r.column_index = r.column_overflow ? COL_IDX_W'(MAX_COLUMNS - 1) : COL_IDX_W'(col_count);
		r.field_type = classify_field();
		r.field_length = 8'(field_len);
		r.last_in_line = last;
		fields_due.insert(fields_due.size(), r);
		if (col_count < MAX_COLUMNS)
			col_count++;
	endtask

	task automatic predict_beat(input logic [7:0] c, input logic eol);
		if (eol) begin
			// A line end closes a field only if that field took any byte but a quote or line break.
			if (field_touched)
				close_field(1'b1);
			quoted_mode = 1'b0;
			col_count = 0;
			reset_field();
		end else if (c == CH_CR || c == CH_LF) begin
			// Line breaks are dropped, even when they equal the separator.
		end else if (quoted_mode) begin
			if (c == CH_QUOTE)
				quoted_mode = 1'b0;
			else
				add_to_field(c);
		end else if (c == sep_char) begin
			// A separator outside quotes always closes a field, empty or not. When the
			// separator is the quote byte, this check comes first.
			close_field(1'b0);
			reset_field();
		end else if (c == CH_QUOTE) begin
			quoted_mode = 1'b1;
		end else begin
			add_to_field(c);
		end
	endtask

	// ---------------------------------------------------------------------------------------
	// Monitor: samples both channels at the rising edge.
	// ---------------------------------------------------------------------------------------
	always @(posedge clk) begin : watch_beats
		result_t want;
		in_fire <= arst_n && in_valid && !in_stall;
		out_fire <= arst_n && out_valid && !out_stall;
		if (arst_n && in_valid && !in_stall)
			predict_beat(char_byte, line_end);
		if (arst_n && out_valid && !out_stall) begin
			if (fields_due.size() == 0) begin
				$error("field beat with nothing expected: column_index %0d field_type %0d",
					column_index, field_type);
				mismatches++;
			end else begin
				want = fields_due.pop_front();
				if (column_index !== want.column_index) begin
					$error("column_index: expected %0d, got %0d", want.column_index, column_index);
					mismatches++;
				end
				if (column_overflow !== want.column_overflow) begin
					$error("column_overflow: expected %0d, got %0d",
						want.column_overflow, column_overflow);
					mismatches++;
				end
				if (field_type !== want.field_type) begin
					$error("field_type: expected %0d, got %0d", want.field_type, field_type);
					mismatches++;
				end
				if (field_length !== want.field_length) begin
					$error("field_length: expected %0d, got %0d", want.field_length, field_length);
					mismatches++;
				end
				if (last_in_line !== want.last_in_line) begin
					$error("last_in_line: expected %0d, got %0d", want.last_in_line, last_in_line);
					mismatches++;
				end
			end
		end
	end

	// ---------------------------------------------------------------------------------------
	// Byte driver. After each accepted beat it waits a drawn number of idle cycles. Now and
	// then it switches to a burst mode with no idling at all.
	// ---------------------------------------------------------------------------------------
	int in_gap = 0;
	bit in_burst = 1'b0;

	always @(negedge clk) begin : drive_bytes
		beat_t nxt;
		if (arst_n) begin
			if (in_valid && !in_fire) begin
				// A stalled beat stays on the bus unchanged.
			end else if (in_gap > 0) begin
				in_valid <= 1'b0;
				in_gap--;
			end else if (beats_pending.size() > 0) begin
				nxt = beats_pending.pop_front();
				in_valid <= 1'b1;
				char_byte <= nxt.ch;
				line_end <= nxt.eol;
				if ($urandom_range(0, 63) == 0)
					in_burst = ~in_burst;
				in_gap = in_burst ? 0 : $urandom_range(0, 14);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Output stall: after each accepted field beat the receiver holds off for a drawn count.
	int out_hold = 0;
	bit out_burst = 1'b0;

	always @(negedge clk) begin : drive_stall
		if (out_fire) begin
			if ($urandom_range(0, 31) == 0)
				out_burst = ~out_burst;
			out_hold = out_burst ? 0 : $urandom_range(0, 14);
		end
		if (out_hold > 0) begin
			out_stall <= 1'b1;
			out_hold--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// ---------------------------------------------------------------------------------------
	// Stimulus building.
	// ---------------------------------------------------------------------------------------
	task automatic put(input logic [7:0] c);
		beats_pending.insert(beats_pending.size(), beat_t'{ch: c, eol: 1'b0});
		stim_count++;
	endtask

	// The byte lane carries junk on a line end beat, since the splitter ignores it there.
	task automatic put_eol();
		beats_pending.insert(beats_pending.size(),
			beat_t'{ch: 8'($urandom_range(0, 255)), eol: 1'b1});
		stim_count++;
	endtask

	task automatic put_str(input string s);
		for (int i = 0; i < s.len(); i++)
			put(s[i]);
	endtask

	function automatic int span(input int lo, input int hi);
		return broken ? $urandom_range(0, hi + 1) : $urandom_range(lo, hi);
	endfunction

	task automatic put_digits(input int n);
		repeat (n) put(8'("0" + $urandom_range(0, 9)));
	endtask

	task automatic put_alpha(input int n);
		int r;
		repeat (n) begin
			r = $urandom_range(0, 51);
			put(r < 26 ? 8'("A" + r) : 8'("a" + r - 26));
		end
	endtask

	task automatic put_numdots(input int n);
		repeat (n) begin
			if ($urandom_range(0, 3) == 0)
				put(CH_DOT);
			else
				put_digits(1);
		end
	endtask

	// Free text: mostly letters, some digits, and space runs of up to four.
	task automatic put_words(input int n);
		int r;
		repeat (n) begin
			r = $urandom_range(0, 9);
			if (r == 0)
				repeat ($urandom_range(1, 4)) put(CH_SPACE);
			else if (r < 3)
				put_digits(1);
			else
				put_alpha(1);
		end
	endtask

	task automatic add_field(input int kind);
		bit quoted;
		quoted = ($urandom_range(0, 5) == 0);
		broken = ($urandom_range(0, 4) == 0);
		if (quoted)
			put(CH_QUOTE);
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) put(CH_SPACE);
		case (kind)
			K_ID: begin
				put_digits(span(1, 3));
				put_alpha(span(2, 3));
				put_digits(span(2, 3));
			end
			K_DATE: begin
				if ($urandom_range(0, 1)) begin
					put_digits(span(1, 2));
					put(CH_MINUS);
				end
				put_alpha(span(2, 3));
				put(CH_MINUS);
				put_digits(span(2, 2));
			end
			K_DOTTED: begin
				put_digits(span(1, 2));
				put(CH_DOT);
				put(CH_SPACE);
				put_alpha(span(2, 3));
				put(CH_SPACE);
				put_digits(span(2, 2));
			end
			K_RANGE: begin
				put_numdots(span(1, 4));
				if ($urandom_range(0, 1))
					put(CH_SPACE);
				if ($urandom_range(0, 1)) begin
					put(CH_MINUS);
				end else begin
					put(CH_LOW_T);
					put(CH_LOW_O);
				end
				if ($urandom_range(0, 1))
					put(CH_SPACE);
				put_numdots(span(1, 4));
			end
			K_DOUBLE: begin
				if ($urandom_range(0, 1))
					put(CH_MINUS);
				put_digits(span(1, 4));
				put(CH_DOT);
				put_digits(span(1, 4));
			end
			K_INT: begin
				if ($urandom_range(0, 1))
					put(CH_MINUS);
				put_digits(span(1, 6));
			end
			K_TEXT: put_words(span(1, 12));
			K_LONG: put_words(span(30, 60));
			K_HUGE: begin
				// A space run long enough to pin the held space count at its ceiling. When
				// the letters after it commit the run, the length lands on its ceiling too.
				put_alpha($urandom_range(1, 8));
				repeat (258) put(CH_SPACE);
				put_alpha(2);
			end
			K_NOISE: repeat ($urandom_range(1, 6)) put(8'($urandom_range(0, 255)));
			default: begin
			end
		endcase
		if ($urandom_range(0, 2) == 0)
			repeat ($urandom_range(1, 3)) put(CH_SPACE);
		if (quoted) begin
			// A separator inside quotes is plain text.
			if ($urandom_range(0, 1))
				put(sep_char);
			put(CH_QUOTE);
		end
	endtask

	// Builds one line of nf fields. Wide lines hold mostly empty fields so that the column
	// counter runs past its end cheaply.
	task automatic add_line(input int nf);
		int k;
		for (int i = 0; i < nf; i++) begin
			if (nf > 8) begin
				add_field($urandom_range(0, 3) == 0 ? K_INT : K_EMPTY);
			end else begin
				k = $urandom_range(K_ID, K_EMPTY);
				if (k == K_HUGE && $urandom_range(0, 19) != 0)
					k = K_TEXT;
				add_field(k);
			end
			// A trailing separator leaves an untouched field, so the line end adds nothing.
			if (i < nf - 1 || $urandom_range(0, 5) == 0)
				put(sep_char);
		end
		case ($urandom_range(0, 3))
			1: begin
				put(CH_CR);
				put(CH_LF);
			end
			2: put(CH_LF);
			default: begin
			end
		endcase
		put_eol();
		if ($urandom_range(0, 7) == 0)
			put_eol();
	endtask

	task automatic fill_lines(input int n_items, input int min_lines, input int max_f);
		int start;
		int lines;
		start = stim_count;
		lines = 0;
		while (stim_count - start < n_items || lines < min_lines) begin
			if (max_f > 8 && $urandom_range(0, 29) == 0)
				add_line($urandom_range(63, 70));
			else
				add_line($urandom_range(1, max_f));
			lines++;
		end
	endtask

	// Waits until every beat has been sent and every field has arrived, then idles on to cover
	// a beat still inside the pipeline that closes no field.
	task automatic settle();
		do
			@(posedge clk);
		while (beats_pending.size() != 0 || in_valid || fields_due.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	// One write then one read back, each with a setup phase and an access phase.
	task automatic write_reg(input logic idx, input logic [7:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= 32'(val);
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (idx == REG_SEPARATOR)
			sep_char = val;
		else
			long_limit = val;
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (prdata !== 32'(val)) begin
			$error("prdata: expected %0d, got %0d", val, prdata);
			mismatches++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic run_phase(input logic [7:0] sep, input logic [7:0] lim, input int n_items,
		input int min_lines, input int max_f);
		settle();
		write_reg(REG_SEPARATOR, sep);
		write_reg(REG_LONG_LIMIT, lim);
		fill_lines(n_items, min_lines, max_f);
	endtask

	// ---------------------------------------------------------------------------------------
	// Test sequence.
	// ---------------------------------------------------------------------------------------
	initial begin : run_test
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Short directed line with the reset settings: an id, a quoted separator, a double,
		// a field with too many inner spaces, NUL and 0xFF as plain text. Then an empty
		// line end, which closes nothing, and a line of only a space, which does.
		put_str("12ab345;\"x;y\";-1.5;a   b\r");
		put(8'h00);
		put(8'hFF);
		put_eol();
		put_eol();
		put(CH_SPACE);
		put_eol();

		// A line past the last column, and a field at the length ceiling.
		add_line(68);
		add_field(K_HUGE);
		put_eol();
		fill_lines(60, 0, 8);

		run_phase(CH_COMMA, 8'd0, 40, 0, 8);
		run_phase(8'd255, 8'd254, 40, 0, 8);
		run_phase(8'd0, 8'($urandom_range(1, 253)), 30, 0, 8);
		// The quote byte as separator: it splits outside quotes and ends a quoted run.
		run_phase(CH_QUOTE, LONG_LIMIT_RESET, 30, 0, 6);
		// A line break as separator is always dropped, so only line ends close fields.
		run_phase(CH_CR, 8'd12, 0, 5, 2);
		run_phase(CH_SPACE, 8'd3, 30, 0, 6);
		run_phase(CH_SEMI, LONG_LIMIT_RESET, 40, 0, 8);

		settle();
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// Guard against a hang.
	initial begin : watchdog
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/cfs_pkg.sv
rtl/core/cfs_field_unit.sv
rtl/core/csv_field_split_and_type_classify.sv
tb/sv/tb.sv
